[rtl/core/gia_pkg.sv]
// ----------------------------------------------------------------------------
// gia_pkg
// Shared types and codes for the generational handle allocator.
// ----------------------------------------------------------------------------
package gia_pkg;

	localparam int GEN_W = 32;

	typedef enum logic [1:0] {
		OP_CREATE  = 2'd0,
		OP_DESTROY = 2'd1,
		OP_QUERY   = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EXEC
	} state_t;

endpackage

[rtl/core/gia_req_if.sv]
// ----------------------------------------------------------------------------
// gia_req_if
// Request channel: opcode and handle, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gia_req_if #(
	parameter int IDX_W = 10
);
	import gia_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [IDX_W-1:0]   handle_index;
	logic [GEN_W-1:0]   handle_generation;

	modport source (output valid, output opcode, output handle_index,
		output handle_generation, input ready);
	modport sink (input valid, input opcode, input handle_index,
		input handle_generation, output ready);
endinterface

[rtl/core/gia_rsp_if.sv]
// ----------------------------------------------------------------------------
// gia_rsp_if
// Response channel: resulting handle, status and issued count.
// ----------------------------------------------------------------------------
interface gia_rsp_if #(
	parameter int IDX_W = 10,
	parameter int CNT_W = 11
);
	import gia_pkg::*;

	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   result_index;
	logic [GEN_W-1:0]   result_generation;
	logic               ok;
	logic [CNT_W-1:0]   issued_count;

	modport source (output valid, output result_index, output result_generation,
		output ok, output issued_count, input ready);
	modport sink (input valid, input result_index, input result_generation,
		input ok, input issued_count, output ready);
endinterface

[rtl/core/gia_ram.sv]
// ----------------------------------------------------------------------------
// gia_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/core/generational_id_allocator_unit.sv]
// ----------------------------------------------------------------------------
// generational_id_allocator_unit
// Generational handle allocator: generation table and free-index FIFO held in
// RAM, create / destroy / query one transaction at a time.
//
//   channel  dir  payload
//   req      in   opcode, handle_index, handle_generation
//   rsp      out  result_index, result_generation, ok, issued_count
//
// Each transaction passes through accept (free FIFO head read), lookup
// (generation table read) and execute (table and FIFO write-back, result load).
// The two dependent RAM reads set that sequence.
// Reset clears the state, counters, pointers and output valid only; RAM contents are not cleared.
// A result waits in the output register; the next request is still accepted,
// and execute holds until the output register is free.
// ----------------------------------------------------------------------------
module generational_id_allocator_unit
	import gia_pkg::*;
#(
	parameter int MAX_HANDLES = 1024
) (
	input  logic  clk,
	input  logic  arst_n,
	gia_req_if.sink   req,
	gia_rsp_if.source rsp
);
	localparam int IDX_W = $clog2(MAX_HANDLES);
	localparam int CNT_W = $clog2(MAX_HANDLES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_HANDLES - 1);
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_HANDLES);

	state_t state_q, state_d;

	logic             in_ready, q_re, tbl_re, exec_go;
	logic [1:0]       op_q;
	logic [IDX_W-1:0] idx_q;
	logic [GEN_W-1:0] gen_q;
	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] free_cnt_q, next_q;

	logic             out_valid_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [GEN_W-1:0] res_gen_q;
	logic             res_ok_q;
	logic [CNT_W-1:0] res_cnt_q;

	logic [IDX_W-1:0] q_rdata, q_waddr;
	logic             q_we;
	logic [GEN_W-1:0] tbl_rdata, tbl_wdata;
	logic [IDX_W-1:0] tbl_raddr, tbl_waddr;
	logic             tbl_we;

	logic [IDX_W-1:0] head_d, tail_d, r_idx;
	logic [CNT_W-1:0] free_cnt_d, next_d;
	logic [GEN_W-1:0] r_gen;
	logic             r_ok, alive;

	gia_ram #(.WIDTH(GEN_W), .DEPTH(MAX_HANDLES)) u_gen_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	gia_ram #(.WIDTH(IDX_W), .DEPTH(MAX_HANDLES)) u_free_fifo (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (idx_q),
		.re    (q_re),
		.raddr (head_q),
		.rdata (q_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (req.valid) state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_EXEC;
			ST_EXEC:   if (exec_go) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		tbl_re   = 1'b0;
		exec_go  = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_LOOKUP: tbl_re = 1'b1;
			ST_EXEC:   exec_go = !out_valid_q || rsp.ready;
			default:   in_ready = 1'b0;
		endcase
	end

	assign q_re      = in_ready && req.valid;
	assign tbl_raddr = (op_q == OP_CREATE) ? q_rdata : idx_q;

	assign alive = (CNT_W'(idx_q) < next_q) && (tbl_rdata == gen_q);

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		free_cnt_d = free_cnt_q;
		next_d     = next_q;
		r_idx      = idx_q;
		r_gen      = gen_q;
		r_ok       = 1'b0;
		tbl_we     = 1'b0;
		tbl_waddr  = idx_q;
		tbl_wdata  = tbl_rdata + GEN_W'(1);
		q_we       = 1'b0;
		q_waddr    = tail_q;
		case (op_q)
			OP_CREATE: begin
				r_idx = '0;
				r_gen = '0;
				if (free_cnt_q != '0) begin
					r_idx      = q_rdata;
					r_gen      = tbl_rdata;
					r_ok       = 1'b1;
					head_d     = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
					free_cnt_d = free_cnt_q - CNT_W'(1);
				end else if (next_q < MAX_CNT) begin
					r_idx     = next_q[IDX_W-1:0];
					r_ok      = 1'b1;
					tbl_we    = exec_go;
					tbl_waddr = next_q[IDX_W-1:0];
					tbl_wdata = '0;
					next_d    = next_q + CNT_W'(1);
				end
			end
			OP_DESTROY: begin
				if (alive) begin
					r_ok   = 1'b1;
					tbl_we = exec_go;
					if (free_cnt_q < MAX_CNT) begin
						q_we       = exec_go;
						tail_d     = (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
						free_cnt_d = free_cnt_q + CNT_W'(1);
					end
				end
			end
			OP_QUERY: r_ok = alive;
			default:  r_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			free_cnt_q  <= '0;
			next_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_go) begin
				head_q      <= head_d;
				tail_q      <= tail_d;
				free_cnt_q  <= free_cnt_d;
				next_q      <= next_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_re) begin
			op_q  <= req.opcode;
			idx_q <= req.handle_index;
			gen_q <= req.handle_generation;
		end
		if (exec_go) begin
			res_idx_q <= r_idx;
			res_gen_q <= r_gen;
			res_ok_q  <= r_ok;
			res_cnt_q <= next_d;
		end
	end

	assign req.ready             = in_ready;
	assign rsp.valid             = out_valid_q;
	assign rsp.result_index      = res_idx_q;
	assign rsp.result_generation = res_gen_q;
	assign rsp.ok                = res_ok_q;
	assign rsp.issued_count      = res_cnt_q;
endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the generational handle allocator. A directed table
// covers reset state, stale and unissued handles, double destroy and unknown
// opcodes. Random traffic, a table fill, a burst of repeated destroys of one
// handle and more random traffic follow, all checked against an in-bench
// model of the allocator.
// ----------------------------------------------------------------------------
module tb_top
	import gia_pkg::*;
();

	localparam int MAX_H          = 1024;
	localparam int IDX_W          = 10;
	localparam int CNT_W          = 11;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [GEN_W-1:0] generation;
		logic             ok;
		logic [CNT_W-1:0] count;
	} alloc_result_t;

	typedef struct {
		opcode_t          op;
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
		bit               typed;
		alloc_result_t    want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	gia_req_if #(.IDX_W(IDX_W)) req_if ();
	gia_rsp_if #(.IDX_W(IDX_W), .CNT_W(CNT_W)) rsp_if ();

	generational_id_allocator_unit #(.MAX_HANDLES(MAX_H)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// allocator model state
	bit [GEN_W-1:0] gen_tbl [MAX_H];
	bit [IDX_W-1:0] free_fifo [$];
	bit [CNT_W-1:0] issued;

	alloc_result_t pending_results [$];
	stim_row_t     directed [$];
	int            mismatches;
	int            idle_mode;
	int            sent;
	int            quiet_cycles;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic alloc_result_t advance_handles(opcode_t op, bit [IDX_W-1:0] idx,
		bit [GEN_W-1:0] gen);
		alloc_result_t r;
		bit            live;
		r.index      = idx;
		r.generation = gen;
		r.ok         = 1'b0;
		live = (idx < issued) && (gen_tbl[idx] == gen);
		case (op)
			OP_CREATE: begin
				r.index      = '0;
				r.generation = '0;
				if (free_fifo.size() > 0) begin
					r.index      = free_fifo.pop_front();
					r.generation = gen_tbl[r.index];
					r.ok         = 1'b1;
				end else if (issued < MAX_H) begin
					r.index         = issued[IDX_W-1:0];
					gen_tbl[issued] = '0;
					issued++;
					r.ok = 1'b1;
				end
			end
			OP_DESTROY: begin
				if (live) begin
					gen_tbl[idx] = gen_tbl[idx] + 1;
					// FIFO full: generation still bumps, push is dropped
					if (free_fifo.size() < MAX_H)
						free_fifo = {free_fifo, idx};
					r.ok = 1'b1;
				end
			end
			OP_QUERY: r.ok = live;
			default: ;
		endcase
		r.count = issued;
		return r;
	endfunction

	function automatic int pick_gap();
		int pct;
		int gap;
		pct = (idle_mode == 1) ? 68 : (idle_mode == 3) ? 31 : 0;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < pct)
			gap++;
		return gap;
	endfunction

	task automatic send(opcode_t op, bit [IDX_W-1:0] idx, bit [GEN_W-1:0] gen,
		bit typed = 1'b0, alloc_result_t want = '0);
		int            gap;
		alloc_result_t pred;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid             <= 1'b1;
		req_if.opcode            <= op;
		req_if.handle_index      <= idx;
		req_if.handle_generation <= gen;
		do @(posedge clk); while (!req_if.ready);
		pred = advance_handles(op, idx, gen);
		pending_results = {pending_results, (typed ? want : pred)};
		sent++;
		idle_mode = (sent / 50) % 4;
	endtask

	// hold the request side until every outstanding transaction has returned
	task automatic drain();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_row(opcode_t op, bit [IDX_W-1:0] idx, bit [GEN_W-1:0] gen,
		bit typed, alloc_result_t want);
		stim_row_t row;
		row.op    = op;
		row.idx   = idx;
		row.gen   = gen;
		row.typed = typed;
		row.want  = want;
		directed = {directed, row};
	endtask

	task automatic random_item();
		int               roll;
		bit [IDX_W-1:0]   idx;
		bit [GEN_W-1:0]   gen;
		roll = $urandom_range(99);
		idx  = (issued == 0) ? '0 : IDX_W'($urandom_range(issued - 1));
		if (roll < 35) begin
			send(OP_CREATE, IDX_W'($urandom), $urandom);
		end else if (roll < 55) begin
			send(OP_DESTROY, idx, gen_tbl[idx]);
		end else if (roll < 60) begin
			gen = $urandom_range(1) ? gen_tbl[idx] + $urandom_range(1, 3) : gen_tbl[idx] - 1;
			send(OP_DESTROY, idx, gen);
		end else if (roll < 75) begin
			send(OP_QUERY, idx, gen_tbl[idx]);
		end else if (roll < 85) begin
			gen = $urandom_range(1) ? $urandom : gen_tbl[idx] + 1;
			send(OP_QUERY, idx, gen);
		end else if (roll < 92) begin
			idx = (issued >= MAX_H) ? IDX_W'($urandom) : IDX_W'($urandom_range(issued, MAX_H - 1));
			send($urandom_range(1) ? OP_DESTROY : OP_QUERY, idx, $urandom_range(1) ? 0 : $urandom);
		end else begin
			send(opcode_t'($urandom_range(3)), IDX_W'($urandom), $urandom);
		end
	endtask

	// response side: check, then pick the next stall
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (rsp_if.valid && rsp_if.ready) begin
					alloc_result_t got;
					alloc_result_t want;
					got.index      = rsp_if.result_index;
					got.generation = rsp_if.result_generation;
					got.ok         = rsp_if.ok;
					got.count      = rsp_if.issued_count;
					if (pending_results.size() == 0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: unexpected result idx=%0d gen=%0h ok=%0b cnt=%0d",
								$realtime, got.index, got.generation, got.ok, got.count);
					end else begin
						want = pending_results.pop_front();
						if (got.index !== want.index || got.generation !== want.generation ||
							got.ok !== want.ok || got.count !== want.count) begin
							mismatches++;
							if (mismatches <= 10)
								$display({"%0t: mismatch exp idx=%0d gen=%0h ok=%0b cnt=%0d",
									" got idx=%0d gen=%0h ok=%0b cnt=%0d"}, $realtime,
									want.index, want.generation, want.ok, want.count,
									got.index, got.generation, got.ok, got.count);
						end
					end
				end
				rsp_if.ready <= ($urandom_range(99) >=
					((idle_mode == 2) ? 68 : (idle_mode == 3) ? 31 : 0));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("watchdog: no transaction for %0d cycles", quiet_cycles);
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n                   = 1'b0;
		req_if.valid             = 1'b0;
		req_if.opcode            = OP_NONE;
		req_if.handle_index      = '0;
		req_if.handle_generation = '0;
		mismatches               = 0;
		idle_mode                = 0;
		sent                     = 0;
		quiet_cycles             = 0;
		issued                   = '0;

		add_row(OP_QUERY,   10'd0,    32'h0,        1'b1, '{10'd0,    32'h0,        1'b0, 11'd0});
		add_row(OP_DESTROY, 10'd1023, 32'hFFFFFFFF, 1'b1, '{10'd1023, 32'hFFFFFFFF, 1'b0, 11'd0});
		add_row(OP_NONE,    10'd1023, 32'hFFFFFFFF, 1'b1, '{10'd1023, 32'hFFFFFFFF, 1'b0, 11'd0});
		add_row(OP_CREATE,  10'd0,    32'h0,        1'b1, '{10'd0,    32'h0,        1'b1, 11'd1});
		add_row(OP_CREATE,  10'd0,    32'h0,        1'b1, '{10'd1,    32'h0,        1'b1, 11'd2});
		add_row(OP_CREATE,  10'd1023, 32'hFFFFFFFF, 1'b1, '{10'd2,    32'h0,        1'b1, 11'd3});
		add_row(OP_QUERY,   10'd0,    32'h0,        1'b0, '0);
		add_row(OP_QUERY,   10'd0,    32'h1,        1'b0, '0);
		add_row(OP_DESTROY, 10'd1,    32'h0,        1'b0, '0);
		add_row(OP_QUERY,   10'd1,    32'h0,        1'b0, '0);
		add_row(OP_QUERY,   10'd1,    32'h1,        1'b0, '0);
		add_row(OP_DESTROY, 10'd1,    32'h1,        1'b0, '0);
		add_row(OP_CREATE,  10'd0,    32'h0,        1'b0, '0);
		add_row(OP_CREATE,  10'd0,    32'h0,        1'b0, '0);
		add_row(OP_DESTROY, 10'd1,    32'h0,        1'b0, '0);
		add_row(OP_DESTROY, 10'd3,    32'h0,        1'b1, '{10'd3,    32'h0,        1'b0, 11'd3});
		add_row(OP_QUERY,   10'd3,    32'h0,        1'b1, '{10'd3,    32'h0,        1'b0, 11'd3});
		add_row(OP_CREATE,  10'd0,    32'h0,        1'b0, '0);
		add_row(OP_QUERY,   10'd3,    32'h0,        1'b0, '0);
		add_row(OP_DESTROY, 10'd2,    32'h0,        1'b0, '0);
		add_row(OP_QUERY,   10'd2,    32'h1,        1'b0, '0);
		add_row(OP_NONE,    10'd0,    32'h0,        1'b1, '{10'd0,    32'h0,        1'b0, 11'd4});
		add_row(OP_QUERY,   10'd1022, 32'hFFFFFFFF, 1'b1, '{10'd1022, 32'hFFFFFFFF, 1'b0, 11'd4});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send(directed[i].op, directed[i].idx, directed[i].gen,
				directed[i].typed, directed[i].want);
		drain();

		repeat (150) random_item();
		drain();

		// fill the table, then creates must fail
		while (free_fifo.size() > 0 || issued < MAX_H) begin
			if ($urandom_range(9) == 0) begin
				bit [IDX_W-1:0] qi;
				qi = IDX_W'($urandom_range(issued - 1));
				send(OP_QUERY, qi, gen_tbl[qi]);
			end else begin
				send(OP_CREATE, '0, '0);
			end
		end
		repeat (3) send(OP_CREATE, IDX_W'($urandom), $urandom);
		send(OP_QUERY, 10'd1023, gen_tbl[1023]);
		drain();

		// one live handle destroyed over and over, queued once per destroy
		repeat (40) begin
			if ($urandom_range(7) == 0)
				send(OP_QUERY, '0, gen_tbl[0] - 1);
			send(OP_DESTROY, '0, gen_tbl[0]);
		end

		repeat (60) random_item();
		drain();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
